>>> sv/mpms_pkg.sv
// Package with shared types and constants of the meter poll and mode-seek supervisor.
`default_nettype none
package mpms_pkg;

   // Width of the event timestamp field.
   localparam int NOW_W = 32;
   // Default width of internal time arithmetic.
   localparam int TIME_BITS_DEF = 32;

   // Configuration register widths.
   localparam int POLL_W  = 13;
   localparam int GAP_W   = 16;
   localparam int COUNT_W = 4;
   localparam int FLOOR_W = 16;
   localparam int CSR_W   = 16;
   localparam int DEAD_W  = 16;

   // Poll interval clamp and staleness multiplier.
   localparam logic [POLL_W-1:0] POLL_MIN    = 13'd50;
   localparam logic [POLL_W-1:0] POLL_MAX    = 13'd5000;
   localparam logic [DEAD_W-1:0] STALE_POLLS = 16'd5;

   // Configuration reset values.
   localparam logic [POLL_W-1:0]  POLL_RST  = 13'd100;
   localparam logic [GAP_W-1:0]   GAP_RST   = 16'd300;
   localparam logic [COUNT_W-1:0] PRESS_RST = 4'd5;
   localparam logic [FLOOR_W-1:0] FLOOR_RST = 16'd500;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_POLL_INTERVAL = 2'd0,
      CSR_PRESS_GAP     = 2'd1,
      CSR_MAX_PRESSES   = 2'd2,
      CSR_STALE_FLOOR   = 2'd3
   } csr_index_type;

   // Event kinds.
   typedef enum logic [2:0] {
      KIND_TICK  = 3'd0,
      KIND_FRAME = 3'd1,
      KIND_SEEK  = 3'd2,
      KIND_STOP  = 3'd3,
      KIND_ERROR = 3'd4
   } kind_type;

   // Commands sent to the meter.
   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_PRESS = 2'd1,
      CMD_POLL  = 2'd2
   } command_type;

   // Meter mode meaning "unknown" or "no seek pending".
   localparam logic [1:0] MODE_NONE = 2'd3;

   // Current configuration register contents.
   typedef struct packed {
      logic [POLL_W-1:0]  poll_interval_ms;
      logic [GAP_W-1:0]   press_gap_ms;
      logic [COUNT_W-1:0] max_presses;
      logic [FLOOR_W-1:0] stale_floor_ms;
   } cfg_type;

   // One request.
   typedef struct packed {
      logic [2:0]       kind;
      logic [NOW_W-1:0] now_ms;
      logic [1:0]       frame_mode;
      logic [1:0]       target_mode;
   } req_item_type;

   // One response.
   typedef struct packed {
      logic [1:0] command;
      logic       alive;
      logic       alive_changed;
      logic       seek_failed;
      logic [1:0] failed_target;
   } rsp_item_type;

endpackage
`default_nettype wire

>>> sv/mpms_req_if.sv
// Request channel interface of the meter poll and mode-seek supervisor.
`default_nettype none
interface mpms_req_if;
   logic                        valid;
   logic                        ready;
   logic [2:0]                  kind;
   logic [mpms_pkg::NOW_W-1:0]  now_ms;
   logic [1:0]                  frame_mode;
   logic [1:0]                  target_mode;

   modport source (output valid, kind, now_ms, frame_mode, target_mode, input ready);
   modport sink   (input valid, kind, now_ms, frame_mode, target_mode, output ready);
endinterface
`default_nettype wire

>>> sv/mpms_rsp_if.sv
// Response channel interface of the meter poll and mode-seek supervisor.
`default_nettype none
interface mpms_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic       alive;
   logic       alive_changed;
   logic       seek_failed;
   logic [1:0] failed_target;

   modport source (output valid, command, alive, alive_changed, seek_failed, failed_target,
                   input ready);
   modport sink   (input valid, command, alive, alive_changed, seek_failed, failed_target,
                   output ready);
endinterface
`default_nettype wire

>>> sv/mpms_csr.sv
// Configuration registers of the meter poll and mode-seek supervisor.
`default_nettype none
module mpms_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [mpms_pkg::CSR_W-1:0]  csr_wdata,
   output mpms_pkg::cfg_type                cfg
);

   mpms_pkg::cfg_type cfg_ff, cfg_in;

   // Decode the write index and truncate data to the register width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (mpms_pkg::csr_index_type'(csr_index))
            mpms_pkg::CSR_POLL_INTERVAL:
               cfg_in.poll_interval_ms = csr_wdata[mpms_pkg::POLL_W-1:0];
            mpms_pkg::CSR_PRESS_GAP:
               cfg_in.press_gap_ms = csr_wdata[mpms_pkg::GAP_W-1:0];
            mpms_pkg::CSR_MAX_PRESSES:
               cfg_in.max_presses = csr_wdata[mpms_pkg::COUNT_W-1:0];
            mpms_pkg::CSR_STALE_FLOOR:
               cfg_in.stale_floor_ms = csr_wdata[mpms_pkg::FLOOR_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poll_interval_ms <= mpms_pkg::POLL_RST;
         cfg_ff.press_gap_ms     <= mpms_pkg::GAP_RST;
         cfg_ff.max_presses      <= mpms_pkg::PRESS_RST;
         cfg_ff.stale_floor_ms   <= mpms_pkg::FLOOR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

>>> sv/mpms_core.sv
// Supervisor state and the per-request update logic.
`default_nettype none
module mpms_core #(
   parameter int TIME_BITS = mpms_pkg::TIME_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mpms_pkg::cfg_type      cfg,
   input  wire logic                   step,
   input  wire mpms_pkg::req_item_type item,
   output mpms_pkg::rsp_item_type      result
);

   logic [1:0]                      seek_target_ff, seek_target_in;
   logic [mpms_pkg::COUNT_W-1:0]    press_count_ff, press_count_in;
   logic [TIME_BITS-1:0]            last_press_ff, last_press_in;
   logic [TIME_BITS-1:0]            last_good_ff, last_good_in;
   logic                            alive_ff, alive_in;
   logic [1:0]                      current_mode_ff, current_mode_in;

   logic [TIME_BITS+mpms_pkg::NOW_W-1:0] now_ext;
   logic [TIME_BITS-1:0]            now_t;
   logic [TIME_BITS-1:0]            good_age;
   logic [TIME_BITS-1:0]            press_age;
   logic [mpms_pkg::POLL_W-1:0]     poll_sat;
   logic [mpms_pkg::DEAD_W-1:0]     poll_dead;
   logic [mpms_pkg::DEAD_W-1:0]     deadline;
   logic                            stale;
   logic                            gap_passed;

   // Timestamp reduced to the internal time width.
   assign now_ext = {{TIME_BITS{1'b0}}, item.now_ms};
   assign now_t   = now_ext[TIME_BITS-1:0];

   // Ages since the last good frame and the last press, modulo the time width.
   assign good_age  = now_t - last_good_ff;
   assign press_age = now_t - last_press_ff;

   // No-frame deadline: max(stale floor, five clamped poll intervals).
   always_comb begin
      poll_sat = cfg.poll_interval_ms;
      if (poll_sat < mpms_pkg::POLL_MIN) poll_sat = mpms_pkg::POLL_MIN;
      if (poll_sat > mpms_pkg::POLL_MAX) poll_sat = mpms_pkg::POLL_MAX;
      poll_dead = mpms_pkg::DEAD_W'(poll_sat) * mpms_pkg::STALE_POLLS;
      deadline  = (cfg.stale_floor_ms > poll_dead) ? cfg.stale_floor_ms : poll_dead;
   end

   assign stale      = good_age > TIME_BITS'(deadline);
   assign gap_passed = press_age >= TIME_BITS'(cfg.press_gap_ms);

   // Next state and response for the request in the input register.
   always_comb begin
      seek_target_in  = seek_target_ff;
      press_count_in  = press_count_ff;
      last_press_in   = last_press_ff;
      last_good_in    = last_good_ff;
      alive_in        = alive_ff;
      current_mode_in = current_mode_ff;
      result.command       = mpms_pkg::CMD_NONE;
      result.seek_failed   = 1'b0;
      result.failed_target = 2'd0;

      case (item.kind)
         mpms_pkg::KIND_TICK: begin
            if (alive_ff && stale) alive_in = 1'b0;
            result.command = mpms_pkg::CMD_POLL;
            if (seek_target_ff != mpms_pkg::MODE_NONE && gap_passed) begin
               if (current_mode_ff == seek_target_ff) begin
                  seek_target_in = mpms_pkg::MODE_NONE;
                  press_count_in = '0;
               end else if (press_count_ff >= cfg.max_presses) begin
                  result.seek_failed   = 1'b1;
                  result.failed_target = seek_target_ff;
                  seek_target_in       = mpms_pkg::MODE_NONE;
                  press_count_in       = '0;
               end else begin
                  last_press_in  = now_t;
                  press_count_in = press_count_ff + 1'b1;
                  result.command = mpms_pkg::CMD_PRESS;
               end
            end
         end
         mpms_pkg::KIND_FRAME: begin
            current_mode_in = item.frame_mode;
            last_good_in    = now_t;
            alive_in        = 1'b1;
         end
         mpms_pkg::KIND_SEEK: begin
            seek_target_in = item.target_mode;
            press_count_in = '0;
            last_press_in  = '0;
         end
         mpms_pkg::KIND_STOP: begin
            seek_target_in = mpms_pkg::MODE_NONE;
            press_count_in = '0;
            alive_in       = 1'b0;
         end
         mpms_pkg::KIND_ERROR: begin
            alive_in = 1'b0;
         end
         default: begin
            // Unused kinds leave the state alone.
            alive_in = alive_ff;
         end
      endcase

      result.alive         = alive_in;
      result.alive_changed = alive_in ^ alive_ff;
   end

   // State advances only when the request moves to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         seek_target_ff  <= mpms_pkg::MODE_NONE;
         press_count_ff  <= '0;
         last_press_ff   <= '0;
         last_good_ff    <= '0;
         alive_ff        <= 1'b0;
         current_mode_ff <= mpms_pkg::MODE_NONE;
      end else if (step) begin
         seek_target_ff  <= seek_target_in;
         press_count_ff  <= press_count_in;
         last_press_ff   <= last_press_in;
         last_good_ff    <= last_good_in;
         alive_ff        <= alive_in;
         current_mode_ff <= current_mode_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/meter_poll_mode_seeker.sv
// Top level of the meter poll and mode-seek supervisor.
// Each request (tick, good frame, seek, stop or link error) is captured in an input
// register, evaluated against the supervisor state combinationally, and its single
// response is held in an output register until taken. While the response side is
// ready the block sustains one request per clock cycle; a response is presented once
// its request has passed from the input register into the output register. While a
// finished response waits, an empty input register still takes one more request;
// the request side stalls only when both registers are full.
// Configuration writes take effect on the next cycle and should be made while no
// request is in flight.
`default_nettype none
module meter_poll_mode_seeker #(
   parameter int TIME_BITS = mpms_pkg::TIME_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   mpms_req_if.sink                         req,
   mpms_rsp_if.source                       rsp,
   input  wire logic                        csr_we,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [mpms_pkg::CSR_W-1:0]  csr_wdata
);

   mpms_pkg::cfg_type      cfg;
   mpms_pkg::req_item_type in_item_ff, in_item_in;
   mpms_pkg::rsp_item_type out_item_ff, out_item_in;
   mpms_pkg::rsp_item_type result;
   logic                   in_valid_ff, in_valid_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   req_fire;
   logic                   advance;

   mpms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mpms_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   // Handshake control of the two register stages.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      in_valid_in  = req_fire || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp.ready);
      in_item_in   = in_item_ff;
      out_item_in  = out_item_ff;
      if (req_fire) begin
         in_item_in.kind        = req.kind;
         in_item_in.now_ms      = req.now_ms;
         in_item_in.frame_mode  = req.frame_mode;
         in_item_in.target_mode = req.target_mode;
      end
      if (advance) out_item_in = result;
   end

   // Valid flags reset; payload registers just load.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   // Response port.
   assign rsp.valid         = out_valid_ff;
   assign rsp.command       = out_item_ff.command;
   assign rsp.alive         = out_item_ff.alive;
   assign rsp.alive_changed = out_item_ff.alive_changed;
   assign rsp.seek_failed   = out_item_ff.seek_failed;
   assign rsp.failed_target = out_item_ff.failed_target;

endmodule
`default_nettype wire

>>> tb/meter_poll_mode_seeker_test.sv
// Self-checking testbench for the meter poll and mode-seek supervisor.
`default_nettype none
module meter_poll_mode_seeker_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mpms_pkg::*;

   // Event kinds the block must ignore.
   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

   // Meter modes other than "unknown".
   localparam logic [1:0] MODE_AVERAGE = 2'd0;
   localparam logic [1:0] MODE_PEAK    = 2'd1;
   localparam logic [1:0] MODE_TUNE    = 2'd2;

   // Poll interval clamp and staleness multiplier as the supervisor applies them.
   localparam logic [31:0] POLL_FLOOR_MS = 32'd50;
   localparam logic [31:0] POLL_CEIL_MS  = 32'd5000;
   localparam logic [31:0] STALE_MULT    = 32'd5;

   // Minimum count of non-spare requests per random phase; five phases in all.
   localparam int PHASE_EVENTS = 310;

   // One line of the directed script: either a register write or a request.
   typedef struct {
      bit            is_write;
      csr_index_type reg_sel;
      logic [15:0]   reg_value;
      logic [2:0]    kind;
      logic [31:0]   now_ms;
      logic [1:0]    frame_mode;
      logic [1:0]    target_mode;
      bit            typed;
      rsp_item_type  want;
   } script_line_type;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [1:0]          csr_index;
   logic [CSR_W-1:0]    csr_wdata;

   mpms_req_if req_ch ();
   mpms_rsp_if rsp_ch ();

   meter_poll_mode_seeker dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register contents as the supervisor should hold them.
   logic [12:0] poll_ms_cfg     = 13'd100;
   logic [15:0] gap_ms_cfg      = 16'd300;
   logic [3:0]  press_limit_cfg = 4'd5;
   logic [15:0] floor_ms_cfg    = 16'd500;

   // Supervisor state as it should evolve.
   logic [1:0]  seek_goal       = MODE_NONE;
   logic [3:0]  press_tally     = 4'd0;
   logic [31:0] press_stamp     = 32'd0;
   logic [31:0] frame_stamp     = 32'd0;
   logic        link_alive      = 1'b0;
   logic [1:0]  meter_seen_mode = MODE_NONE;

   rsp_item_type expected_replies[$];
   rsp_item_type last_outcome;
   bit           script_typed = 1'b0;
   rsp_item_type script_want;
   bit           steady = 1'b0;
   int           errors = 0;
   int           events_sent = 0;
   logic [31:0]  wall_ms;
   logic [1:0]   meter_mode = MODE_AVERAGE;

   // No-frame deadline: the larger of the floor and five clamped poll periods.
   function automatic logic [31:0] stale_limit();
      logic [31:0] poll_ms;
      logic [31:0] limit_ms;
      poll_ms = 32'(poll_ms_cfg);
      if (poll_ms < POLL_FLOOR_MS) poll_ms = POLL_FLOOR_MS;
      if (poll_ms > POLL_CEIL_MS) poll_ms = POLL_CEIL_MS;
      limit_ms = STALE_MULT * poll_ms;
      if (32'(floor_ms_cfg) > limit_ms) limit_ms = 32'(floor_ms_cfg);
      return limit_ms;
   endfunction

   // Applies one request to the predicted state and returns the response it should give.
   function automatic rsp_item_type supervise_event(logic [2:0] kind, logic [31:0] now,
                                                    logic [1:0] fmode, logic [1:0] tmode);
      rsp_item_type res;
      logic         was_alive;
      res = '0;
      was_alive = link_alive;
      case (kind)
         KIND_TICK: begin
            if (link_alive && (now - frame_stamp) > stale_limit()) link_alive = 1'b0;
            res.command = CMD_POLL;
            if (seek_goal != MODE_NONE && (now - press_stamp) >= 32'(gap_ms_cfg)) begin
               if (meter_seen_mode == seek_goal) begin
                  seek_goal = MODE_NONE;
                  press_tally = 4'd0;
               end else if (press_tally >= press_limit_cfg) begin
                  res.seek_failed = 1'b1;
                  res.failed_target = seek_goal;
                  seek_goal = MODE_NONE;
                  press_tally = 4'd0;
               end else begin
                  press_stamp = now;
                  press_tally = press_tally + 4'd1;
                  res.command = CMD_PRESS;
               end
            end
         end
         KIND_FRAME: begin
            meter_seen_mode = fmode;
            frame_stamp = now;
            link_alive = 1'b1;
         end
         KIND_SEEK: begin
            seek_goal = tmode;
            press_tally = 4'd0;
            press_stamp = 32'd0;
         end
         KIND_STOP: begin
            seek_goal = MODE_NONE;
            press_tally = 4'd0;
            link_alive = 1'b0;
         end
         KIND_ERROR: begin
            link_alive = 1'b0;
         end
         default: ;
      endcase
      res.alive = link_alive;
      res.alive_changed = link_alive != was_alive;
      return res;
   endfunction

   function automatic script_line_type event_line(logic [2:0] kind, logic [31:0] now,
                                                  logic [1:0] fmode, logic [1:0] tmode,
                                                  bit typed, command_type cmd, bit alive,
                                                  bit changed, bit failed,
                                                  logic [1:0] ftarget);
      script_line_type line;
      line = '{reg_sel: CSR_POLL_INTERVAL, default: '0};
      line.kind = kind;
      line.now_ms = now;
      line.frame_mode = fmode;
      line.target_mode = tmode;
      line.typed = typed;
      line.want.command = cmd;
      line.want.alive = alive;
      line.want.alive_changed = changed;
      line.want.seek_failed = failed;
      line.want.failed_target = ftarget;
      return line;
   endfunction

   function automatic script_line_type write_line(csr_index_type sel, logic [15:0] value);
      script_line_type line;
      line = '{reg_sel: CSR_POLL_INTERVAL, default: '0};
      line.is_write = 1'b1;
      line.reg_sel = sel;
      line.reg_value = value;
      return line;
   endfunction

   // Offers one request, with random idle cycles ahead of it, and waits until it is taken.
   task automatic send_event(logic [2:0] kind, logic [31:0] now, logic [1:0] fmode,
                             logic [1:0] tmode);
      while (!steady && $urandom_range(99) < 35) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= kind;
      req_ch.now_ms <= now;
      req_ch.frame_mode <= fmode;
      req_ch.target_mode <= tmode;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      if (kind <= KIND_ERROR) events_sent++;
   endtask

   // Holds off new requests until every outstanding response has come back.
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes one register; called only while the block is idle.
   task automatic write_csr(csr_index_type sel, logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (sel)
         CSR_POLL_INTERVAL: poll_ms_cfg = value[12:0];
         CSR_PRESS_GAP:     gap_ms_cfg = value;
         CSR_MAX_PRESSES:   press_limit_cfg = value[3:0];
         default:           floor_ms_cfg = value;
      endcase
      @(negedge clock);
   endtask

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The response side stalls at random except during the steady phase.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= steady || ($urandom_range(99) >= 35);
      end
   end

   // Checks each response against the oldest expectation, then predicts each new request.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_replies.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_ch.command !== want.command) begin
                  $error("command: expected %0d, actual %0d", want.command, rsp_ch.command);
                  errors++;
               end
               if (rsp_ch.alive !== want.alive) begin
                  $error("alive: expected %0d, actual %0d", want.alive, rsp_ch.alive);
                  errors++;
               end
               if (rsp_ch.alive_changed !== want.alive_changed) begin
                  $error("alive_changed: expected %0d, actual %0d", want.alive_changed,
                         rsp_ch.alive_changed);
                  errors++;
               end
               if (rsp_ch.seek_failed !== want.seek_failed) begin
                  $error("seek_failed: expected %0d, actual %0d", want.seek_failed,
                         rsp_ch.seek_failed);
                  errors++;
               end
               if (rsp_ch.failed_target !== want.failed_target) begin
                  $error("failed_target: expected %0d, actual %0d", want.failed_target,
                         rsp_ch.failed_target);
                  errors++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            last_outcome = supervise_event(req_ch.kind, req_ch.now_ms, req_ch.frame_mode,
                                           req_ch.target_mode);
            expected_replies.push_back(script_typed ? script_want : last_outcome);
         end
      end
   end

   // Stimulus: directed script first, then five random phases under different settings.
   initial begin
      script_line_type script[$];
      int              phase;
      int              phase_goal;
      int              steps;
      int              burst;
      int              pick;
      int              j;
      logic [1:0]      goal;

      req_ch.valid = 1'b0;
      req_ch.kind = KIND_TICK;
      req_ch.now_ms = '0;
      req_ch.frame_mode = MODE_AVERAGE;
      req_ch.target_mode = MODE_AVERAGE;
      csr_we = 1'b0;
      csr_index = CSR_POLL_INTERVAL;
      csr_wdata = '0;
      reset = 1'b1;

      // Default settings: deadline 500 ms, press gap 300 ms, five presses.
      script.push_back(event_line(KIND_TICK, 32'd0, MODE_AVERAGE, MODE_AVERAGE, 1,
                                  CMD_POLL, 0, 0, 0, MODE_AVERAGE));
      script.push_back(event_line(KIND_FRAME, 32'd100, MODE_AVERAGE, MODE_TUNE, 1,
                                  CMD_NONE, 1, 1, 0, MODE_AVERAGE));
      // Exactly at the deadline the meter is still alive; one past it, it is not.
      script.push_back(event_line(KIND_TICK, 32'd600, MODE_NONE, MODE_PEAK, 1,
                                  CMD_POLL, 1, 0, 0, MODE_AVERAGE));
      script.push_back(event_line(KIND_TICK, 32'd601, MODE_AVERAGE, MODE_AVERAGE, 1,
                                  CMD_POLL, 0, 1, 0, MODE_AVERAGE));
      script.push_back(event_line(KIND_FRAME, 32'd700, MODE_PEAK, MODE_AVERAGE, 1,
                                  CMD_NONE, 1, 1, 0, MODE_AVERAGE));
      // A seek presses once, waits out the gap, then ends when the mode matches.
      script.push_back(event_line(KIND_SEEK, 32'd710, MODE_NONE, MODE_TUNE, 1,
                                  CMD_NONE, 1, 0, 0, MODE_AVERAGE));
      script.push_back(event_line(KIND_TICK, 32'd720, MODE_AVERAGE, MODE_AVERAGE, 1,
                                  CMD_PRESS, 1, 0, 0, MODE_AVERAGE));
      script.push_back(event_line(KIND_TICK, 32'd1019, MODE_AVERAGE, MODE_AVERAGE, 0,
                                  CMD_NONE, 0, 0, 0, MODE_AVERAGE));
      script.push_back(event_line(KIND_FRAME, 32'd1010, MODE_TUNE, MODE_NONE, 0,
                                  CMD_NONE, 0, 0, 0, MODE_AVERAGE));
      script.push_back(event_line(KIND_TICK, 32'd1020, MODE_AVERAGE, MODE_AVERAGE, 1,
                                  CMD_POLL, 1, 0, 0, MODE_AVERAGE));
      // A seek for the unknown mode leaves nothing pending.
      script.push_back(event_line(KIND_SEEK, 32'd1030, MODE_AVERAGE, MODE_NONE, 1,
                                  CMD_NONE, 1, 0, 0, MODE_AVERAGE));
      script.push_back(event_line(KIND_TICK, 32'd1400, MODE_AVERAGE, MODE_AVERAGE, 1,
                                  CMD_POLL, 1, 0, 0, MODE_AVERAGE));
      // Link errors drop alive; a second one changes nothing.
      script.push_back(event_line(KIND_ERROR, 32'd1410, MODE_PEAK, MODE_PEAK, 1,
                                  CMD_NONE, 0, 1, 0, MODE_AVERAGE));
      script.push_back(event_line(KIND_ERROR, 32'd1420, MODE_AVERAGE, MODE_AVERAGE, 1,
                                  CMD_NONE, 0, 0, 0, MODE_AVERAGE));
      script.push_back(event_line(KIND_FRAME, 32'd1430, MODE_NONE, MODE_AVERAGE, 1,
                                  CMD_NONE, 1, 1, 0, MODE_AVERAGE));
      // Stop cancels the pending seek and drops alive.
      script.push_back(event_line(KIND_SEEK, 32'd1440, MODE_TUNE, MODE_AVERAGE, 1,
                                  CMD_NONE, 1, 0, 0, MODE_AVERAGE));
      script.push_back(event_line(KIND_STOP, 32'd1450, MODE_AVERAGE, MODE_TUNE, 1,
                                  CMD_NONE, 0, 1, 0, MODE_AVERAGE));
      script.push_back(event_line(KIND_TICK, 32'd1800, MODE_AVERAGE, MODE_AVERAGE, 1,
                                  CMD_POLL, 0, 0, 0, MODE_AVERAGE));
      // Unused kinds are ignored.
      script.push_back(event_line(KIND_SPARE_FIRST, 32'd1810, MODE_TUNE, MODE_PEAK, 1,
                                  CMD_NONE, 0, 0, 0, MODE_AVERAGE));
      script.push_back(event_line(KIND_SPARE_LAST, 32'hFFFF_FFFF, MODE_NONE, MODE_NONE, 1,
                                  CMD_NONE, 0, 0, 0, MODE_AVERAGE));
      // The staleness check spans the timestamp wrap.
      script.push_back(event_line(KIND_FRAME, 32'hFFFF_FF00, MODE_AVERAGE, MODE_AVERAGE, 1,
                                  CMD_NONE, 1, 1, 0, MODE_AVERAGE));
      script.push_back(event_line(KIND_TICK, 32'h0000_0100, MODE_AVERAGE, MODE_AVERAGE, 1,
                                  CMD_POLL, 0, 1, 0, MODE_AVERAGE));
      // With a press limit of zero an unmatched seek fails on its first due tick.
      script.push_back(event_line(KIND_SEEK, 32'h0000_0110, MODE_AVERAGE, MODE_PEAK, 1,
                                  CMD_NONE, 0, 0, 0, MODE_AVERAGE));
      script.push_back(write_line(CSR_MAX_PRESSES, 16'd0));
      script.push_back(event_line(KIND_TICK, 32'h0000_0300, MODE_AVERAGE, MODE_AVERAGE, 1,
                                  CMD_POLL, 0, 0, 1, MODE_PEAK));

      // Synchronous reset, released at a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         if (script[i].is_write) begin
            drain_responses();
            write_csr(script[i].reg_sel, script[i].reg_value);
         end else begin
            script_typed = script[i].typed;
            script_want = script[i].want;
            send_event(script[i].kind, script[i].now_ms, script[i].frame_mode,
                       script[i].target_mode);
         end
      end
      script_typed = 1'b0;

      wall_ms = $urandom;
      for (phase = 0; phase < 5; phase++) begin
         // Settings change only once the block has gone quiet.
         drain_responses();
         case (phase)
            0: write_csr(CSR_MAX_PRESSES, 16'd5);
            1: begin
               write_csr(CSR_POLL_INTERVAL, 16'd0);
               write_csr(CSR_PRESS_GAP, 16'd0);
               write_csr(CSR_MAX_PRESSES, 16'd0);
               write_csr(CSR_STALE_FLOOR, 16'd0);
            end
            2: begin
               write_csr(CSR_POLL_INTERVAL, 16'hFFFF);
               write_csr(CSR_PRESS_GAP, 16'hFFFF);
               write_csr(CSR_MAX_PRESSES, 16'hFFFF);
               write_csr(CSR_STALE_FLOOR, 16'hFFFF);
            end
            3: begin
               write_csr(CSR_POLL_INTERVAL, 16'($urandom_range(8191)));
               write_csr(CSR_PRESS_GAP, 16'($urandom_range(1000)));
               write_csr(CSR_MAX_PRESSES, 16'($urandom_range(15)));
               write_csr(CSR_STALE_FLOOR, 16'($urandom_range(2000)));
            end
            default: begin
               write_csr(CSR_POLL_INTERVAL, 16'($urandom));
               write_csr(CSR_PRESS_GAP, 16'($urandom));
               write_csr(CSR_MAX_PRESSES, 16'($urandom));
               write_csr(CSR_STALE_FLOOR, 16'($urandom));
            end
         endcase
         steady = (phase == 2);
         phase_goal = events_sent + PHASE_EVENTS;

         while (events_sent < phase_goal) begin
            if ($urandom_range(99) < 75) begin
               // A seek session against an emulated meter that steps its mode on a press.
               if ($urandom_range(2) != 0) begin
                  wall_ms += $urandom_range(50);
                  send_event(KIND_FRAME, wall_ms, meter_mode, 2'($urandom));
               end
               goal = ($urandom_range(9) == 0) ? MODE_NONE : 2'($urandom_range(MODE_TUNE));
               wall_ms += $urandom_range(50);
               send_event(KIND_SEEK, wall_ms, 2'($urandom), goal);
               steps = $urandom_range(24, 3);
               for (j = 0; j < steps; j++) begin
                  pick = $urandom_range(99);
                  if (pick < 60) begin
                     case ($urandom_range(3))
                        0: wall_ms += $urandom_range(40);
                        1, 2: wall_ms += $urandom_range(32'(gap_ms_cfg) * 3 / 2 + 10,
                                                          32'(gap_ms_cfg) / 2);
                        default: wall_ms += $urandom_range(2 * stale_limit() + 2);
                     endcase
                     send_event(KIND_TICK, wall_ms, 2'($urandom), 2'($urandom));
                     // The meter usually, but not always, reacts to a press.
                     if (last_outcome.command == CMD_PRESS && $urandom_range(9) < 8)
                        meter_mode = (meter_mode == MODE_TUNE) ? MODE_AVERAGE : meter_mode + 2'd1;
                  end else if (pick < 90) begin
                     wall_ms += $urandom_range(50);
                     send_event(KIND_FRAME, wall_ms,
                                ($urandom_range(19) == 0) ? MODE_NONE : meter_mode,
                                2'($urandom));
                  end else if (pick < 95) begin
                     wall_ms += $urandom_range(50);
                     send_event(KIND_ERROR, wall_ms, 2'($urandom), 2'($urandom));
                  end else if (pick < 97) begin
                     wall_ms += $urandom_range(50);
                     send_event(KIND_STOP, wall_ms, 2'($urandom), 2'($urandom));
                  end else begin
                     wall_ms += $urandom_range(50);
                     send_event(KIND_SEEK, wall_ms, 2'($urandom), 2'($urandom));
                  end
               end
            end else begin
               // Noise: any kind, with timestamps that sometimes jump anywhere.
               burst = $urandom_range(8, 1);
               for (j = 0; j < burst; j++) begin
                  if ($urandom_range(3) == 0) wall_ms = $urandom;
                  else wall_ms += $urandom_range(2 * stale_limit() + 2);
                  send_event(3'($urandom_range(KIND_SPARE_LAST)), wall_ms, 2'($urandom),
                             2'($urandom));
               end
            end
            if ($urandom_range(39) == 0) drain_responses();
         end
      end
      steady = 1'b0;

      drain_responses();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #1_600_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
`default_nettype wire
